// ===== rtl/dab_fig_record_parser_assert.svh =====
// ----------------------------------------------------------------------------
// dab_fig_record_parser assertion macros
// shared concurrent assertion forms, sampled on clk, held off during reset
// ----------------------------------------------------------------------------
`ifndef DAB_FIG_RECORD_PARSER_ASSERT_SVH
`define DAB_FIG_RECORD_PARSER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define DFRP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define DFRP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/dfrp_pkg.sv =====
// ----------------------------------------------------------------------------
// dfrp_pkg
// types and constants shared by the type 0 FIG record parser
// ----------------------------------------------------------------------------
`default_nettype none

package dfrp_pkg;

    localparam int unsigned DATA_BYTES_DEF = 30;

    localparam logic [4:0] FIB_LAST_POS = 5'd31;
    localparam logic [7:0] END_MARKER   = 8'hff;

    localparam logic [4:0] EXT_ENSEMBLE   = 5'd0;
    localparam logic [4:0] EXT_SUBCHANNEL = 5'd1;
    localparam logic [4:0] EXT_SERVICE    = 5'd2;

    localparam logic [2:0] ENS_FIELD_BYTES = 3'd3;
    localparam logic [2:0] SUB_SHORT_BYTES = 3'd2;
    localparam logic [2:0] SID_SHORT_BYTES = 3'd2;
    localparam logic [2:0] SID_LONG_BYTES  = 3'd4;

    localparam logic [1:0] KIND_ENSEMBLE   = 2'd0;
    localparam logic [1:0] KIND_SUBCHANNEL = 2'd1;
    localparam logic [1:0] KIND_COMPONENT  = 2'd2;

    typedef enum logic [2:0] {
        PH_HEADER    = 3'd0,
        PH_EXTENSION = 3'd1,
        PH_SKIP      = 3'd2,
        PH_ENSEMBLE  = 3'd3,
        PH_SUBCHAN   = 3'd4,
        PH_SERVICE   = 3'd5,
        PH_COUNT     = 3'd6,
        PH_COMPONENT = 3'd7
    } phase_t;

    typedef struct packed {
        logic [1:0]  record_kind;
        logic [15:0] ensemble_id;
        logic [4:0]  frame_count_high;
        logic [7:0]  frame_count_low;
        logic [5:0]  subchannel_id;
        logic [9:0]  start_address;
        logic        long_form;
        logic [5:0]  table_index;
        logic [4:0]  protection_level;
        logic [9:0]  subchannel_size;
        logic [5:0]  component_type;
    } record_t;

endpackage

`default_nettype wire

// ===== rtl/dab_fig_record_parser.sv =====
// ----------------------------------------------------------------------------
// dab_fig_record_parser
// type 0 FIG record extraction from a 32-byte fast information block
//
//   channel | direction | payload                         | handshake
//   --------+-----------+---------------------------------+--------------------
//   input   | in        | block_byte, start, crc_good     | in_valid/in_ready
//   output  | out       | record fields, one per result   | out_valid/out_ready
//
// one FIB byte is taken per cycle while in_ready is high; each record is registered
// in the output slot, or in the skid register while the output stalls; the field decode
// is a single pass from the state registers to the result slot; in_ready drops only while
// both output slots (output and skid register) are full; asynchronous reset clears the
// parser state and both slots
`default_nettype none

module dab_fig_record_parser
    import dfrp_pkg::*;
#(
    parameter int unsigned DATA_BYTES = DATA_BYTES_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  block_byte,
    input  wire logic        block_start,
    input  wire logic        block_crc_good,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       record_kind,
    output logic [15:0]      ensemble_id,
    output logic [4:0]       frame_count_high,
    output logic [7:0]       frame_count_low,
    output logic [5:0]       subchannel_id,
    output logic [9:0]       start_address,
    output logic             long_form,
    output logic [5:0]       table_index,
    output logic [4:0]       protection_level,
    output logic [9:0]       subchannel_size,
    output logic [5:0]       component_type
);

    logic    accept;
    logic    res_valid;
    record_t res;
    logic    space;
    record_t out_data;

    assign in_ready = space;
    assign accept   = in_valid && space;

    dfrp_decoder #(
        .DATA_BYTES (DATA_BYTES)
    ) u_decoder (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .block_byte     (block_byte),
        .block_start    (block_start),
        .block_crc_good (block_crc_good),
        .res_valid      (res_valid),
        .res            (res)
    );

    dfrp_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .space     (space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign record_kind      = out_data.record_kind;
    assign ensemble_id      = out_data.ensemble_id;
    assign frame_count_high = out_data.frame_count_high;
    assign frame_count_low  = out_data.frame_count_low;
    assign subchannel_id    = out_data.subchannel_id;
    assign start_address    = out_data.start_address;
    assign long_form        = out_data.long_form;
    assign table_index      = out_data.table_index;
    assign protection_level = out_data.protection_level;
    assign subchannel_size  = out_data.subchannel_size;
    assign component_type   = out_data.component_type;

endmodule

`default_nettype wire

// ===== rtl/dfrp_decoder.sv =====
// ----------------------------------------------------------------------------
// dfrp_decoder
// per-byte FIB walker: group headers, type 0 extension 0/1/2 field decode
// ----------------------------------------------------------------------------
`default_nettype none

module dfrp_decoder
    import dfrp_pkg::*;
#(
    parameter int unsigned DATA_BYTES = DATA_BYTES_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [7:0] block_byte,
    input  wire logic       block_start,
    input  wire logic       block_crc_good,
    output logic            res_valid,
    output record_t         res
);

`include "dab_fig_record_parser_assert.svh"

    localparam logic [4:0] DATA_LIMIT = 5'(DATA_BYTES);

    logic [4:0]  pos_reg,    pos_next;
    logic        active_reg, active_next;
    logic [4:0]  left_reg,   left_next;
    phase_t      phase_reg,  phase_next;
    logic        dsf_reg,    dsf_next;
    logic [2:0]  fbi_reg,    fbi_next;
    logic [23:0] shift_reg,  shift_next;
    logic [3:0]  comp_reg,   comp_next;

    // state as seen by this byte, a block start clears everything but takes active from block_crc_good
    phase_t      cur_phase;
    logic [4:0]  cur_left;
    logic        cur_dsf;
    logic [2:0]  cur_fbi;
    logic [23:0] cur_shift;
    logic [3:0]  cur_comp;
    logic [4:0]  pos_step;
    logic        active_step;
    logic        parse_en;
    logic [4:0]  left_dec;
    logic [2:0]  fbi_inc;
    logic [23:0] shift_push;
    logic [3:0]  comp_dec;
    logic [7:0]  held_byte;

    always_comb
    begin
        cur_phase = block_start ? PH_HEADER : phase_reg;
        cur_left  = block_start ? 5'd0  : left_reg;
        cur_dsf   = block_start ? 1'b0  : dsf_reg;
        cur_fbi   = block_start ? 3'd0  : fbi_reg;
        cur_shift = block_start ? 24'd0 : shift_reg;
        cur_comp  = block_start ? 4'd0  : comp_reg;
        if (block_start)
        begin
            pos_step    = 5'd0;
            active_step = block_crc_good;
        end
        else if (pos_reg < FIB_LAST_POS)
        begin
            pos_step    = pos_reg + 5'd1;
            active_step = active_reg;
        end
        else
        begin
            pos_step    = pos_reg;
            active_step = 1'b0;
        end
    end

    assign parse_en   = active_step && (pos_step < DATA_LIMIT);
    assign left_dec   = cur_left - 5'd1;
    assign fbi_inc    = cur_fbi + 3'd1;
    assign shift_push = {cur_shift[15:0], block_byte};
    assign comp_dec   = cur_comp - 4'd1;
    assign held_byte  = cur_shift[7:0];

    // next state
    always_comb
    begin
        pos_next    = pos_reg;
        active_next = active_reg;
        left_next   = left_reg;
        phase_next  = phase_reg;
        dsf_next    = dsf_reg;
        fbi_next    = fbi_reg;
        shift_next  = shift_reg;
        comp_next   = comp_reg;
        if (accept)
        begin
            pos_next    = pos_step;
            active_next = active_step;
            left_next   = cur_left;
            phase_next  = cur_phase;
            dsf_next    = cur_dsf;
            fbi_next    = cur_fbi;
            shift_next  = cur_shift;
            comp_next   = cur_comp;
            if (parse_en)
            begin
                if (cur_phase == PH_HEADER)
                begin
                    if (block_byte == END_MARKER)
                    begin
                        active_next = 1'b0;
                    end
                    else if (block_byte[4:0] != 5'd0)
                    begin
                        left_next  = block_byte[4:0];
                        phase_next = (block_byte[7:5] == 3'd0) ? PH_EXTENSION : PH_SKIP;
                    end
                end
                else
                begin
                    left_next = left_dec;
                    unique case (cur_phase)
                        PH_EXTENSION:
                        begin
                            dsf_next   = block_byte[5];
                            fbi_next   = 3'd0;
                            shift_next = 24'd0;
                            priority if (block_byte[4:0] == EXT_ENSEMBLE)
                                phase_next = PH_ENSEMBLE;
                            else if (block_byte[4:0] == EXT_SUBCHANNEL)
                                phase_next = PH_SUBCHAN;
                            else if (block_byte[4:0] == EXT_SERVICE)
                                phase_next = PH_SERVICE;
                            else
                                phase_next = PH_SKIP;
                        end
                        PH_ENSEMBLE:
                        begin
                            if (cur_fbi < ENS_FIELD_BYTES)
                            begin
                                shift_next = shift_push;
                                fbi_next   = fbi_inc;
                            end
                            else
                            begin
                                phase_next = PH_SKIP;
                            end
                        end
                        PH_SUBCHAN:
                        begin
                            if (cur_fbi < SUB_SHORT_BYTES ||
                                (cur_fbi == SUB_SHORT_BYTES && block_byte[7]))
                            begin
                                shift_next = shift_push;
                                fbi_next   = fbi_inc;
                            end
                            else
                            begin
                                fbi_next   = 3'd0;
                                shift_next = 24'd0;
                            end
                        end
                        PH_SERVICE:
                        begin
                            fbi_next = fbi_inc;
                            if (fbi_inc >= (cur_dsf ? SID_LONG_BYTES : SID_SHORT_BYTES))
                            begin
                                fbi_next   = 3'd0;
                                phase_next = PH_COUNT;
                            end
                        end
                        PH_COUNT:
                        begin
                            comp_next  = block_byte[3:0];
                            fbi_next   = 3'd0;
                            shift_next = 24'd0;
                            phase_next = (block_byte[3:0] != 4'd0) ? PH_COMPONENT : PH_SERVICE;
                        end
                        PH_COMPONENT:
                        begin
                            if (cur_fbi == 3'd0)
                            begin
                                shift_next = shift_push;
                                fbi_next   = fbi_inc;
                            end
                            else
                            begin
                                fbi_next   = 3'd0;
                                shift_next = 24'd0;
                                comp_next  = comp_dec;
                                if (comp_dec == 4'd0)
                                    phase_next = PH_SERVICE;
                            end
                        end
                        default:
                        begin
                            // skipped group body, nothing to pick up
                        end
                    endcase
                    // group exhausted, whatever was part-way is dropped
                    if (left_dec == 5'd0)
                    begin
                        phase_next = PH_HEADER;
                        fbi_next   = 3'd0;
                        shift_next = 24'd0;
                        comp_next  = 4'd0;
                    end
                end
            end
        end
    end

    // result of this byte
    always_comb
    begin
        res_valid = 1'b0;
        res       = '0;
        if (accept && parse_en && cur_phase != PH_HEADER)
        begin
            unique case (cur_phase)
                PH_ENSEMBLE:
                begin
                    if (!(cur_fbi < ENS_FIELD_BYTES))
                    begin
                        res_valid            = 1'b1;
                        res.record_kind      = KIND_ENSEMBLE;
                        res.ensemble_id      = cur_shift[23:8];
                        res.frame_count_high = cur_shift[4:0];
                        res.frame_count_low  = block_byte;
                    end
                end
                PH_SUBCHAN:
                begin
                    if (cur_fbi == SUB_SHORT_BYTES && !block_byte[7])
                    begin
                        res_valid         = 1'b1;
                        res.record_kind   = KIND_SUBCHANNEL;
                        res.subchannel_id = cur_shift[15:10];
                        res.start_address = cur_shift[9:0];
                        res.table_index   = block_byte[5:0];
                    end
                    else if (cur_fbi > SUB_SHORT_BYTES)
                    begin
                        res_valid            = 1'b1;
                        res.record_kind      = KIND_SUBCHANNEL;
                        res.subchannel_id    = cur_shift[23:18];
                        res.start_address    = cur_shift[17:8];
                        res.long_form        = 1'b1;
                        res.protection_level = {held_byte[6:4], held_byte[3:2]};
                        res.subchannel_size  = {held_byte[1:0], block_byte};
                    end
                end
                PH_COMPONENT:
                begin
                    // only TMid 0 (audio stream) components are reported
                    if (cur_fbi != 3'd0 && held_byte[7:6] == 2'd0)
                    begin
                        res_valid          = 1'b1;
                        res.record_kind    = KIND_COMPONENT;
                        res.subchannel_id  = block_byte[7:2];
                        res.component_type = held_byte[5:0];
                    end
                end
                default:
                begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= 5'd0;
            active_reg <= 1'b0;
            left_reg   <= 5'd0;
            phase_reg  <= PH_HEADER;
            dsf_reg    <= 1'b0;
            fbi_reg    <= 3'd0;
            shift_reg  <= 24'd0;
            comp_reg   <= 4'd0;
        end
        else
        begin
            pos_reg    <= pos_next;
            active_reg <= active_next;
            left_reg   <= left_next;
            phase_reg  <= phase_next;
            dsf_reg    <= dsf_next;
            fbi_reg    <= fbi_next;
            shift_reg  <= shift_next;
            comp_reg   <= comp_next;
        end
    end

    `DFRP_ASSERT_SAME(a_body_has_bytes, phase_reg != PH_HEADER, left_reg != 5'd0,
        "group body phase with no bytes left")
    `DFRP_ASSERT_SAME(a_component_count, phase_reg == PH_COMPONENT, comp_reg != 4'd0,
        "component phase with zero components left")
    `DFRP_ASSERT_SAME(a_field_index_range, 1'b1, fbi_reg <= 3'd3,
        "field byte index out of range")

endmodule

`default_nettype wire

// ===== rtl/dfrp_out_buf.sv =====
// ----------------------------------------------------------------------------
// dfrp_out_buf
// two-slot result buffer: output register plus skid register
// ----------------------------------------------------------------------------
`default_nettype none

module dfrp_out_buf
    import dfrp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire record_t push_data,
    output logic         space,
    output logic         out_valid,
    input  wire logic    out_ready,
    output record_t      out_data
);

`include "dab_fig_record_parser_assert.svh"

    logic    out_valid_reg,  out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    record_t out_reg,        out_next;
    record_t skid_reg,       skid_next;
    logic    pop;

    assign pop       = out_valid_reg && out_ready;
    assign space     = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = push;
                skid_next       = push_data;
            end
            else
            begin
                out_valid_next = push;
                out_next       = push_data;
            end
        end
        else if (push)
        begin
            // output stalled, park the new transaction
            skid_valid_next = 1'b1;
            skid_next       = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    `DFRP_ASSERT_SAME(a_skid_behind_out, skid_valid_reg, out_valid_reg,
        "skid slot full while output slot empty")
    `DFRP_ASSERT_NEXT(a_stall_parks, out_valid_reg && !out_ready && push, skid_valid_reg,
        "result pushed during a stall was not parked")
    `DFRP_ASSERT_NEXT(a_drain_empties, pop && !skid_valid_reg && !push, !out_valid_reg,
        "output still valid after its last transaction left")

endmodule

`default_nettype wire
